[rtl/rsrd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsrd_pkg
// Shared types and constants of the RGBE scanline run-length decoder.
// ----------------------------------------------------------------------------
package rsrd_pkg;

    localparam int unsigned POS_W   = 15;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned PIXEL_W = 32;

    // Widest line that may use the per-plane format
    localparam logic [POS_W-1:0] MAX_LINE      = 15'd32767;
    localparam logic [POS_W-1:0] MIN_NEW_WIDTH = 15'd8;
    localparam logic [POS_W-1:0] WIDTH_RESET   = 15'd1024;

    // Decode phases
    localparam logic [2:0] PH_HEADER  = 3'd0;
    localparam logic [2:0] PH_HDR_G   = 3'd1;
    localparam logic [2:0] PH_HDR_B   = 3'd2;
    localparam logic [2:0] PH_HDR_E   = 3'd3;
    localparam logic [2:0] PH_OLD     = 3'd4;
    localparam logic [2:0] PH_CODE    = 3'd5;
    localparam logic [2:0] PH_RUNVAL  = 3'd6;
    localparam logic [2:0] PH_LITERAL = 3'd7;

    // Fill targets
    localparam logic [2:0] TGT_PIXEL = 3'd4;
    localparam logic [1:0] PLANE_EXP = 2'd3;

    localparam logic [BYTE_W-1:0] HDR_TAG    = 8'd2;
    localparam logic [23:0]       REPEAT_TAG = 24'h010101;
    localparam logic [BYTE_W-1:0] RUN_LIMIT  = 8'd128;
    localparam logic [4:0]        SHIFT_MAX  = 5'd24;
    localparam logic [4:0]        SHIFT_STEP = 5'd8;
    localparam logic [1:0]        GROUP_LAST = 2'd3;

    typedef struct packed {
        logic [2:0]         target;
        logic [POS_W-1:0]   start;
        logic [POS_W-1:0]   count;
        logic [PIXEL_W-1:0] value;
        logic               done;
        logic               ovr;
    } t_fill;

endpackage

[rtl/rsrd_decode.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsrd_decode
// Input register, decode state and the single-pass step logic that turns
// one byte into at most one fill command.
// ----------------------------------------------------------------------------
module rsrd_decode import rsrd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [7:0]       i_byte,
    input  logic [POS_W-1:0] i_width,
    input  logic             i_out_free,
    output logic             o_res_valid,
    output t_fill            o_res
);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic [2:0]       r_phase,   n_phase;
    logic [1:0]       r_bgrp,    n_bgrp;
    logic [23:0]      r_partial, n_partial;
    logic [31:0]      r_prev,    n_prev;
    logic [POS_W-1:0] r_pos,     n_pos;
    logic [1:0]       r_plane,   n_plane;
    logic [7:0]       r_pending, n_pending;
    logic [4:0]       r_shift,   n_shift;

    logic             advance;
    logic [POS_W-1:0] eff_w;
    logic [POS_W-1:0] rem;
    logic             is_repeat;
    logic [31:0]      shifted;
    logic [31:0]      f_req;
    logic             f_ovr;
    logic [POS_W-1:0] f_cnt;
    logic             f_end;
    logic [7:0]       pend_dec;
    logic             lit_last;
    logic             do_pix;
    logic             do_plane;
    logic             plane_ovr_in;
    logic [31:0]      fill_val;

    assign advance = r_in_valid && i_out_free;
    assign o_ready = !r_in_valid || advance;

    assign eff_w = (i_width == '0) ? POS_W'(1) : i_width;
    assign rem   = (r_pos < eff_w) ? (eff_w - r_pos) : POS_W'(1);

    assign is_repeat = (r_phase == PH_OLD) && (r_bgrp == GROUP_LAST)
                       && (r_partial == REPEAT_TAG);
    assign shifted   = {24'd0, r_in_byte} << r_shift;
    assign f_req     = is_repeat ? shifted
                     : (r_phase == PH_RUNVAL) ? {24'd0, r_pending} : 32'd1;
    assign f_ovr     = (f_req[31:POS_W] != '0) || (f_req[POS_W-1:0] > rem);
    assign f_cnt     = f_ovr ? rem : f_req[POS_W-1:0];
    assign f_end     = (f_cnt == rem);

    assign pend_dec  = (r_pending != 8'd0) ? (r_pending - 8'd1) : 8'd0;
    assign lit_last  = (pend_dec == 8'd0);

    always_comb begin
        n_phase      = r_phase;
        n_bgrp       = r_bgrp;
        n_partial    = r_partial;
        n_prev       = r_prev;
        n_pos        = r_pos;
        n_plane      = r_plane;
        n_pending    = r_pending;
        n_shift      = r_shift;
        do_pix       = 1'b0;
        do_plane     = 1'b0;
        plane_ovr_in = 1'b0;
        fill_val     = r_prev;

        case (r_phase)
            PH_HEADER: begin
                if (eff_w < MIN_NEW_WIDTH || eff_w > MAX_LINE || r_in_byte != HDR_TAG) begin
                    // first byte of an old-format pixel
                    n_phase   = PH_OLD;
                    n_bgrp    = 2'd1;
                    n_partial = {16'd0, r_in_byte};
                    n_shift   = '0;
                end else begin
                    n_phase = PH_HDR_G;
                end
            end
            PH_HDR_G: begin
                n_partial = {8'd0, r_in_byte, 8'd0};
                n_phase   = PH_HDR_B;
            end
            PH_HDR_B: begin
                n_partial = {8'd0, r_partial[15:8], r_in_byte};
                n_phase   = PH_HDR_E;
            end
            PH_HDR_E: begin
                if (r_partial[15:8] != HDR_TAG || r_partial[7]) begin
                    // flat pixel, rest of the line in the old format
                    n_prev    = {HDR_TAG, r_partial[15:0], r_in_byte};
                    fill_val  = n_prev;
                    n_partial = '0;
                    n_bgrp    = '0;
                    n_shift   = '0;
                    n_phase   = PH_OLD;
                    do_pix    = 1'b1;
                end else begin
                    n_partial = '0;
                    n_plane   = '0;
                    n_pos     = '0;
                    n_phase   = PH_CODE;
                end
            end
            PH_OLD: begin
                if (r_bgrp != GROUP_LAST) begin
                    n_partial = {r_partial[15:0], r_in_byte};
                    n_bgrp    = r_bgrp + 2'd1;
                end else begin
                    n_bgrp = '0;
                    if (is_repeat) begin
                        n_shift = (r_shift >= SHIFT_MAX) ? SHIFT_MAX : (r_shift + SHIFT_STEP);
                        do_pix  = (f_req != 32'd0);
                    end else begin
                        n_shift  = '0;
                        n_prev   = {r_partial, r_in_byte};
                        fill_val = n_prev;
                        do_pix   = 1'b1;
                    end
                end
            end
            PH_CODE: begin
                if (r_in_byte > RUN_LIMIT) begin
                    n_pending = {1'b0, r_in_byte[6:0]};
                    n_phase   = PH_RUNVAL;
                end else if (r_in_byte != 8'd0) begin
                    // clamp a literal run, remember that it was clamped
                    n_bgrp    = ({7'd0, r_in_byte} > rem) ? 2'd1 : 2'd0;
                    n_pending = ({7'd0, r_in_byte} > rem) ? rem[7:0] : r_in_byte;
                    n_phase   = PH_LITERAL;
                end
            end
            PH_RUNVAL: begin
                do_plane = 1'b1;
                n_phase  = PH_CODE;
            end
            default: begin
                n_pending    = pend_dec;
                plane_ovr_in = lit_last & r_bgrp[0];
                do_plane     = 1'b1;
                n_phase      = lit_last ? PH_CODE : PH_LITERAL;
            end
        endcase

        // Apply the effect of a fill on the line position
        if (do_pix || do_plane) begin
            if (f_end && (do_pix || r_plane == PLANE_EXP)) begin
                n_phase   = PH_HEADER;
                n_bgrp    = '0;
                n_partial = '0;
                n_pos     = '0;
                n_plane   = '0;
                n_pending = '0;
                n_shift   = '0;
            end else if (do_plane && f_end) begin
                n_plane   = r_plane + 2'd1;
                n_pos     = '0;
                n_pending = '0;
                n_bgrp    = '0;
                n_phase   = PH_CODE;
            end else begin
                n_pos = r_pos + f_cnt;
            end
        end
    end

    always_comb begin
        o_res_valid  = advance && (do_pix || do_plane);
        o_res.target = do_pix ? TGT_PIXEL : {1'b0, r_plane};
        o_res.start  = r_pos;
        o_res.count  = f_cnt;
        o_res.value  = do_pix ? fill_val : {24'd0, r_in_byte};
        o_res.done   = f_end && (do_pix || r_plane == PLANE_EXP);
        o_res.ovr    = f_ovr || plane_ovr_in;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HEADER;
            r_bgrp    <= '0;
            r_partial <= '0;
            r_prev    <= '0;
            r_pos     <= '0;
            r_plane   <= '0;
            r_pending <= '0;
            r_shift   <= '0;
        end else if (advance) begin
            r_phase   <= n_phase;
            r_bgrp    <= n_bgrp;
            r_partial <= n_partial;
            r_prev    <= n_prev;
            r_pos     <= n_pos;
            r_plane   <= n_plane;
            r_pending <= n_pending;
            r_shift   <= n_shift;
        end
    end

endmodule

[rtl/rsrd_out_reg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsrd_out_reg
// Result register holding one fill command until the sink takes it.
// ----------------------------------------------------------------------------
module rsrd_out_reg import rsrd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_load,
    input  t_fill i_res,
    input  logic  i_ready,
    output logic  o_free,
    output logic  o_valid,
    output t_fill o_res
);

    logic  r_valid;
    t_fill r_res;

    // slot is free when empty or being drained this cycle
    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

[rtl/rgbe_scanline_rle_decoder_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbe_scanline_rle_decoder_core
// RGBE scanline run-length decoder emitting fill commands for a line memory.
// ----------------------------------------------------------------------------
// Feed the encoded pixel bytes one per item; each byte yields at most one fill
// command (target plane or whole pixel, start, count, value). One byte is taken
// every cycle while the result register drains: a byte passes the input
// register and the decode step, and its fill lands in the result register.
// Write line_width only while the decoder is idle; widths below 8 force the
// old pixel format.
module rgbe_scanline_rle_decoder_core import rsrd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // configuration: line_width
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [POS_W-1:0] i_cfg_data,
    // input bytes
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  logic [7:0]       i_s_axis_tdata,   // data_byte
    // fill commands
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    output logic [63:0]      o_m_axis_tdata,   // start_index, fill_count, fill_value, overrun
    output logic [2:0]       o_m_axis_tuser,   // fill_target
    output logic             o_m_axis_tlast    // line_done
);

    logic [POS_W-1:0] r_width;
    logic             out_free;
    logic             res_valid;
    t_fill            res;
    t_fill            out_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= WIDTH_RESET;
        end else if (i_cfg_valid) begin
            r_width <= i_cfg_data;
        end
    end

    rsrd_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_byte      (i_s_axis_tdata),
        .i_width     (r_width),
        .i_out_free  (out_free),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    rsrd_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_valid),
        .i_res   (res),
        .i_ready (i_m_axis_tready),
        .o_free  (out_free),
        .o_valid (o_m_axis_tvalid),
        .o_res   (out_res)
    );

    assign o_m_axis_tdata = {1'b0, out_res.ovr, out_res.value, out_res.count, out_res.start};
    assign o_m_axis_tuser = out_res.target;
    assign o_m_axis_tlast = out_res.done;

endmodule

[test/rgbe_fill_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbe_fill_checker
// Watches the byte, configuration and fill channels of the RGBE scanline
// decoder, works out the fill command each accepted byte should produce and
// compares every accepted fill, field by field, with the oldest one pending.
// ----------------------------------------------------------------------------
module rgbe_fill_checker import rsrd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [POS_W-1:0]   i_cfg_data,
    input  logic               i_byte_valid,
    input  logic               i_byte_ready,
    input  logic [7:0]         i_byte,
    input  logic               i_fill_valid,
    input  logic               i_fill_ready,
    input  logic [63:0]        i_fill_data,    // start_index, fill_count, fill_value, overrun
    input  logic [2:0]         i_fill_target,  // fill_target
    input  logic               i_fill_last,    // line_done
    output int                 o_errors,
    output int                 o_outstanding,
    output int                 o_fills,
    output int                 o_lines
);

    logic [POS_W-1:0] width_q;
    logic [2:0]       phase;
    logic [1:0]       grp;
    logic [23:0]      part;
    logic [31:0]      prev_px;
    logic [POS_W-1:0] pos;
    logic [1:0]       plane;
    logic [7:0]       pend;
    logic [4:0]       shift;

    t_fill expected_fills[$];
    int    err_cnt  = 0;
    int    fill_cnt = 0;
    int    line_cnt = 0;

    function automatic int unsigned line_len();
        return (width_q == '0) ? 1 : int'(width_q);
    endfunction

    // pixels left in the plane or the line; one once the width is passed
    function automatic int unsigned left_in_line();
        int unsigned w;
        w = line_len();
        return (pos < w) ? w - pos : 1;
    endfunction

    task automatic begin_line();
        phase = PH_HEADER;
        grp   = '0;
        part  = '0;
        pos   = '0;
        plane = '0;
        pend  = '0;
        shift = '0;
    endtask

    task automatic queue_fill(input logic [2:0] tgt, input int unsigned cnt,
                              input logic [31:0] val, input logic done, input logic ovr);
        t_fill f;
        f.target = tgt;
        f.start  = pos;
        f.count  = cnt[POS_W-1:0];
        f.value  = val;
        f.done   = done;
        f.ovr    = ovr;
        expected_fills.push_back(f);
    endtask

    task automatic fill_pixels(input longint unsigned req, input logic [31:0] val);
        int unsigned r;
        int unsigned c;
        logic        ovr;
        logic        done;
        r    = left_in_line();
        ovr  = (req > r);
        c    = ovr ? r : 32'(req);
        done = (c == r);
        queue_fill(TGT_PIXEL, c, val, done, ovr);
        if (done) begin
            begin_line();
        end else begin
            pos = pos + c[POS_W-1:0];
        end
    endtask

    task automatic fill_plane(input int unsigned cnt, input logic [7:0] val,
                              input logic ovr_in, input logic [2:0] next_phase);
        int unsigned r;
        int unsigned c;
        logic        plane_end;
        logic        done;
        r         = left_in_line();
        c         = (cnt > r) ? r : cnt;
        plane_end = (c == r);
        done      = plane_end && (plane == PLANE_EXP);
        queue_fill({1'b0, plane}, c, {24'b0, val}, done, (cnt > r) | ovr_in);
        if (done) begin
            begin_line();
        end else if (plane_end) begin
            // next plane restarts at position zero; leftover literals are dropped
            plane = plane + 2'd1;
            pos   = '0;
            pend  = '0;
            grp   = '0;
            phase = PH_CODE;
        end else begin
            pos   = pos + c[POS_W-1:0];
            phase = next_phase;
        end
    endtask

    task automatic old_format_byte(input logic [7:0] b);
        longint unsigned req;
        if (grp < GROUP_LAST) begin
            part = {part[15:0], b};
            grp  = grp + 2'd1;
        end else begin
            grp = '0;
            if (part == REPEAT_TAG) begin
                req   = longint'(b) << shift;
                shift = (shift >= SHIFT_MAX) ? SHIFT_MAX : shift + SHIFT_STEP;
                if (req != 0) begin
                    fill_pixels(req, prev_px);
                end
            end else begin
                shift   = '0;
                prev_px = {part, b};
                fill_pixels(1, prev_px);
            end
        end
    endtask

    task automatic decode_byte(input logic [7:0] b);
        int unsigned w;
        int unsigned r;
        logic        last;
        w = line_len();
        case (phase)
            PH_HEADER: begin
                if (w < MIN_NEW_WIDTH || w > MAX_LINE || b != HDR_TAG) begin
                    phase = PH_OLD;
                    grp   = '0;
                    part  = '0;
                    shift = '0;
                    old_format_byte(b);
                end else begin
                    phase = PH_HDR_G;
                end
            end
            PH_HDR_G: begin
                part  = {8'b0, b, 8'b0};
                phase = PH_HDR_B;
            end
            PH_HDR_B: begin
                part  = {8'b0, part[15:8], b};
                phase = PH_HDR_E;
            end
            PH_HDR_E: begin
                if (part[15:8] != HDR_TAG || part[7]) begin
                    // flat pixel: write it, then carry on in the old format
                    prev_px = {HDR_TAG, part[15:0], b};
                    part    = '0;
                    grp     = '0;
                    shift   = '0;
                    phase   = PH_OLD;
                    fill_pixels(1, prev_px);
                end else begin
                    part  = '0;
                    plane = '0;
                    pos   = '0;
                    phase = PH_CODE;
                end
            end
            PH_OLD: begin
                old_format_byte(b);
            end
            PH_CODE: begin
                if (b > RUN_LIMIT) begin
                    pend  = {1'b0, b[6:0]};
                    phase = PH_RUNVAL;
                end else if (b != 8'd0) begin
                    r     = left_in_line();
                    grp   = (b > r) ? 2'd1 : 2'd0;
                    pend  = (b > r) ? r[7:0] : b;
                    phase = PH_LITERAL;
                end
            end
            PH_RUNVAL: begin
                fill_plane(32'(pend), b, 1'b0, PH_CODE);
            end
            default: begin
                if (pend > 0) begin
                    pend = pend - 8'd1;
                end
                last = (pend == 0);
                fill_plane(1, b, last & grp[0], last ? PH_CODE : PH_LITERAL);
            end
        endcase
    endtask

    always @(posedge i_clk) begin : monitor
        t_fill want;
        t_fill got;
        if (!i_rst_n) begin
            width_q = WIDTH_RESET;
            prev_px = '0;
            begin_line();
            expected_fills.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                width_q = i_cfg_data;
            end
            if (i_byte_valid && i_byte_ready) begin
                decode_byte(i_byte);
            end
            if (i_fill_valid && i_fill_ready) begin
                got.target = i_fill_target;
                got.start  = i_fill_data[POS_W-1:0];
                got.count  = i_fill_data[2*POS_W-1:POS_W];
                got.value  = i_fill_data[2*POS_W+PIXEL_W-1:2*POS_W];
                got.ovr    = i_fill_data[2*POS_W+PIXEL_W];
                got.done   = i_fill_last;
                fill_cnt++;
                if (expected_fills.size() == 0) begin
                    $error("fill item with nothing pending: target %0d start %0d count %0d",
                           got.target, got.start, got.count);
                    err_cnt++;
                end else begin
                    want = expected_fills.pop_front();
                    if (want.done) begin
                        line_cnt++;
                    end
                    if (got.target != want.target) begin
                        $error("fill_target: expected %0d, got %0d", want.target, got.target);
                        err_cnt++;
                    end
                    if (got.start != want.start) begin
                        $error("start_index: expected %0d, got %0d", want.start, got.start);
                        err_cnt++;
                    end
                    if (got.count != want.count) begin
                        $error("fill_count: expected %0d, got %0d", want.count, got.count);
                        err_cnt++;
                    end
                    if (got.value != want.value) begin
                        $error("fill_value: expected %h, got %h", want.value, got.value);
                        err_cnt++;
                    end
                    if (got.done != want.done) begin
                        $error("line_done: expected %0d, got %0d", want.done, got.done);
                        err_cnt++;
                    end
                    if (got.ovr != want.ovr) begin
                        $error("overrun: expected %0d, got %0d", want.ovr, got.ovr);
                        err_cnt++;
                    end
                end
            end
        end
        o_errors      <= err_cnt;
        o_outstanding <= expected_fills.size();
        o_fills       <= fill_cnt;
        o_lines       <= line_cnt;
    end

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives encoded scanline bytes into the RGBE run-length decoder: a short
// directed set of lines, then random new-format, flat and old-format lines at
// a range of line widths, with random gaps on both sides. A checker beside
// the block predicts and compares every fill command.
// ----------------------------------------------------------------------------
module tb import rsrd_pkg::*; ();

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_BYTES    = 130;

    logic             clk;
    logic             rst_n      = 1'b0;
    logic             cfg_valid  = 1'b0;
    logic             cfg_ready;
    logic [POS_W-1:0] cfg_data   = '0;
    logic             byte_valid = 1'b0;
    logic             byte_ready;
    logic [7:0]       byte_data  = '0;
    logic             fill_valid;
    logic             fill_ready = 1'b0;
    logic [63:0]      fill_data;
    logic [2:0]       fill_target;
    logic             fill_last;

    int errors;
    int outstanding;
    int fills;
    int lines;

    bit          steady     = 1'b1;
    int          bytes_sent = 0;
    int          idle_run   = 0;
    int unsigned cur_width  = 32'(WIDTH_RESET);
    logic [7:0]  line_bytes[$];

    rgbe_scanline_rle_decoder_core dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (byte_valid),
        .o_s_axis_tready (byte_ready),
        .i_s_axis_tdata  (byte_data),
        .o_m_axis_tvalid (fill_valid),
        .i_m_axis_tready (fill_ready),
        .o_m_axis_tdata  (fill_data),
        .o_m_axis_tuser  (fill_target),
        .o_m_axis_tlast  (fill_last)
    );

    rgbe_fill_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data),
        .i_byte_valid  (byte_valid),
        .i_byte_ready  (byte_ready),
        .i_byte        (byte_data),
        .i_fill_valid  (fill_valid),
        .i_fill_ready  (fill_ready),
        .i_fill_data   (fill_data),
        .i_fill_target (fill_target),
        .i_fill_last   (fill_last),
        .o_errors      (errors),
        .o_outstanding (outstanding),
        .o_fills       (fills),
        .o_lines       (lines)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // fill receiver: stall now and then unless in a steady stretch
    always @(posedge clk) begin
        if (!rst_n) begin
            fill_ready <= 1'b0;
        end else begin
            fill_ready <= steady || ($urandom_range(0, 99) >= 6);
        end
    end

    always @(posedge clk) begin
        if ((byte_valid && byte_ready) || (fill_valid && fill_ready) ||
            (cfg_valid && cfg_ready)) begin
            idle_run <= 0;
        end else begin
            idle_run <= idle_run + 1;
        end
        if (idle_run >= WATCHDOG_LIMIT) begin
            $display("[rgbe_scanline_rle_decoder_core] ERROR");
            $finish;
        end
    end

    function automatic int unsigned min_u(input int unsigned a, input int unsigned b);
        return (a < b) ? a : b;
    endfunction

    function automatic int unsigned line_len(input int unsigned w);
        return (w == 0) ? 1 : w;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        if (!steady && $urandom_range(0, 99) < 3) begin
            byte_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_data  <= b;
        @(posedge clk);
        while (!byte_ready) @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_line(input int cut);
        for (int i = 0; i < cut; i++) begin
            send_byte(line_bytes[i]);
        end
        line_bytes.delete();
    endtask

    // hold the byte channel and wait until every pending fill has come out
    task automatic drain();
        byte_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_width(input int unsigned w);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= w[POS_W-1:0];
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        cur_width = w;
    endtask

    task automatic push_bytes(input logic [7:0] b0, input logic [7:0] b1,
                              input logic [7:0] b2, input logic [7:0] b3);
        line_bytes.push_back(b0);
        line_bytes.push_back(b1);
        line_bytes.push_back(b2);
        line_bytes.push_back(b3);
    endtask

    task automatic push_repeat(input logic [7:0] n);
        push_bytes(REPEAT_TAG[23:16], REPEAT_TAG[15:8], REPEAT_TAG[7:0], n);
    endtask

    // old-format pixels and repeats until rem_in pixels are covered
    task automatic gen_old_body(input int unsigned rem_in, input bit first_in);
        int unsigned     rem;
        int unsigned     shift_g;
        int unsigned     n;
        longint unsigned req;
        bit              first;
        logic [7:0]      b0;
        rem     = rem_in;
        first   = first_in;
        shift_g = 0;
        while (rem > 0) begin
            if ($urandom_range(0, 9) < 4) begin
                if ($urandom_range(0, 3) == 0) begin
                    n = 0;
                end else if ($urandom_range(0, 7) == 0) begin
                    n = $urandom_range(1, 255);
                end else begin
                    n = $urandom_range(1, min_u(rem, 255));
                end
                req     = longint'(n) << shift_g;
                shift_g = (shift_g >= 24) ? 24 : shift_g + 8;
                rem     = (req >= rem) ? 0 : rem - 32'(req);
                push_repeat(n[7:0]);
            end else begin
                b0 = 8'($urandom);
                // keep the opening byte off the header tag
                if (first && line_len(cur_width) >= MIN_NEW_WIDTH && b0 == HDR_TAG) begin
                    b0 = HDR_TAG + 8'd1;
                end
                push_bytes(b0, 8'($urandom), 8'($urandom), 8'($urandom));
                shift_g = 0;
                rem--;
            end
            first = 1'b0;
        end
    endtask

    task automatic gen_new_line(input int unsigned w);
        int unsigned rem;
        int unsigned cap;
        int unsigned n;
        push_bytes(HDR_TAG, HDR_TAG, 8'($urandom_range(0, 127)), 8'($urandom));
        for (int p = 0; p < 4; p++) begin
            rem = w;
            while (rem > 0) begin
                n = $urandom_range(0, 19);
                if (n == 0) begin
                    line_bytes.push_back(8'd0);
                end else if (n < 11) begin
                    cap = min_u(127, rem);
                    if ($urandom_range(0, 7) == 0) begin
                        n = $urandom_range(1, 127);
                    end else if (w > 256) begin
                        n = $urandom_range((cap + 1) / 2, cap);
                    end else begin
                        n = $urandom_range(1, cap);
                    end
                    line_bytes.push_back(RUN_LIMIT + n[7:0]);
                    line_bytes.push_back(8'($urandom));
                    rem = rem - min_u(n, rem);
                end else begin
                    cap = min_u((w > 256) ? 16 : 128, rem);
                    if ($urandom_range(0, 7) == 0) begin
                        n = $urandom_range(1, 128);
                    end else begin
                        n = $urandom_range(1, cap);
                    end
                    line_bytes.push_back(n[7:0]);
                    // an over-long literal only takes what the plane still holds
                    repeat (min_u(n, rem)) line_bytes.push_back(8'($urandom));
                    rem = rem - min_u(n, rem);
                end
            end
        end
    endtask

    task automatic gen_line(input int unsigned w);
        int unsigned k;
        logic [7:0]  g;
        logic [7:0]  bb;
        k = $urandom_range(0, 99);
        if (k < 4) begin
            repeat ($urandom_range(1, 12)) line_bytes.push_back(8'($urandom));
        end else if (w >= MIN_NEW_WIDTH && w <= 2048 && k < 60) begin
            gen_new_line(w);
        end else if (k < 75) begin
            g  = 8'($urandom);
            bb = 8'($urandom);
            if (g == HDR_TAG && !bb[7]) begin
                bb[7] = 1'b1;
            end
            push_bytes(HDR_TAG, g, bb, 8'($urandom));
            gen_old_body(w - 1, 1'b0);
        end else begin
            gen_old_body(w, 1'b1);
        end
    endtask

    initial begin : stimulus
        int unsigned widths[10];
        int          phase_bytes;
        int          cut;
        widths = '{8, 1, 0, 32767, 5, 16, 1024, 9, 255, 100};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: repeats of a pixel never written, then a chained repeat
        set_width(8);
        push_repeat(8'd5);
        push_repeat(8'd1);
        send_line(line_bytes.size());

        // directed: new format with an empty code, a clamped literal and run
        push_bytes(HDR_TAG, HDR_TAG, 8'h00, 8'h08);
        line_bytes.push_back(8'h00);
        line_bytes.push_back(8'h83);
        line_bytes.push_back(8'hff);
        line_bytes.push_back(8'h80);
        push_bytes(8'h00, 8'ha5, 8'h5a, 8'hff);
        line_bytes.push_back(8'h01);
        push_bytes(8'hff, 8'h00, 8'hc0, 8'h55);
        line_bytes.push_back(8'h88);
        line_bytes.push_back(8'haa);
        // flat pixel, a zero repeat and a shifted clamped repeat
        push_bytes(HDR_TAG, 8'h03, 8'h80, 8'h11);
        push_repeat(8'd0);
        push_repeat(8'd1);
        send_line(line_bytes.size());

        // directed: widest line, then the width drops below the position
        set_width(32767);
        push_bytes(HDR_TAG, HDR_TAG, 8'h7f, 8'hff);
        line_bytes.push_back(8'hff);
        line_bytes.push_back(8'h12);
        send_line(line_bytes.size());
        set_width(8);
        push_bytes(8'h81, 8'h34, 8'h88, 8'h01);
        push_bytes(8'h88, 8'h02, 8'h88, 8'h03);
        send_line(line_bytes.size());

        steady = 1'b0;
        for (int ph = 0; ph < 10; ph++) begin
            set_width(widths[ph]);
            steady      = (ph == 5);
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES) begin
                gen_line(line_len(cur_width));
                cut = line_bytes.size();
                // now and then leave the last line of a phase unfinished
                if (phase_bytes + cut >= PHASE_BYTES && $urandom_range(0, 4) == 0) begin
                    cut = $urandom_range(1, cut);
                end
                send_line(cut);
                phase_bytes += cut;
            end
        end

        drain();
        $display("Sent %0d bytes over ten line widths; %0d fills checked, %0d scanlines done.",
                 bytes_sent, fills, lines);
        if (outstanding != 0) begin
            $error("%0d fill items still pending at the end", outstanding);
        end
        if (errors == 0 && outstanding == 0) begin
            $display("[rgbe_scanline_rle_decoder_core] OK");
        end else begin
            $display("[rgbe_scanline_rle_decoder_core] ERROR");
        end
        $finish;
    end

endmodule

[rgbe_scanline_rle_decoder_core.f]
rtl/rsrd_pkg.sv
rtl/rsrd_decode.sv
rtl/rsrd_out_reg.sv
rtl/rgbe_scanline_rle_decoder_core.sv
test/rgbe_fill_checker.sv
test/tb.sv
